@@ hdl/vn_pkg.sv @@
// Shared types and constants for the vector normalization pipeline.
`default_nettype none
package vn_pkg;

   localparam int COMP_W   = 16;
   localparam int LANES    = 4;
   localparam int SQ_W     = 31;
   localparam int SUM_W    = 33;
   localparam int RAD_W    = 49;
   localparam int ACC_W    = 50;
   localparam int LEN_W    = 25;
   localparam int QUO_W    = 15;
   localparam int REM_W    = 25;
   localparam int THR_W    = 33;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 64;

   localparam int SQRT_STG = 25;
   localparam int DIV_STG  = 16;

   // absolute stage numbers along the pipe
   localparam int ST_IN    = 0;
   localparam int ST_SQ    = 1;
   localparam int ST_SUM   = 2;
   localparam int ST_ROOT0 = 3;
   localparam int ST_DIV0  = ST_ROOT0 + SQRT_STG;
   localparam int ST_OUT   = ST_DIV0 + DIV_STG;
   localparam int NUM_STG  = ST_OUT + 1;

   localparam logic [CSR_AW-1:0] ADDR_MIN_SQ_LEN = 4'h0;
   localparam logic [QUO_W-1:0]  UNIT_MAX        = 15'h7fff;

   typedef struct packed {
      logic [2:0]         component_count;
      logic signed [15:0] comp_x;
      logic signed [15:0] comp_y;
      logic signed [15:0] comp_z;
      logic signed [15:0] comp_w;
   } req_type;

   typedef struct packed {
      logic signed [15:0] unit_x;
      logic signed [15:0] unit_y;
      logic signed [15:0] unit_z;
      logic signed [15:0] unit_w;
      logic [24:0]        length;
      logic               degenerate;
   } rsp_type;

   // what a divide lane hands to the output stage
   typedef struct packed {
      logic             neg;
      logic             sat;
      logic [QUO_W-1:0] quo;
   } div_res_type;

endpackage
`default_nettype wire

@@ hdl/vn_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module vn_sqrt import vn_pkg::*; (
   input  wire logic                clock,
   input  wire logic [SQRT_STG-1:0] en,
   input  wire logic [RAD_W-1:0]    rad,
   output logic      [LEN_W-1:0]    root
);

   logic [RAD_W-1:0] rem_ff [SQRT_STG];
   logic [ACC_W-1:0] acc_ff [SQRT_STG];

   for (genvar k = 0; k < SQRT_STG; k++) begin : g_stg
      localparam logic [ACC_W-1:0] BIT_VAL = ACC_W'(1) << (2 * (SQRT_STG - 1 - k));
      logic [RAD_W-1:0] rem_prev;
      logic [ACC_W-1:0] acc_prev;
      logic [ACC_W-1:0] trial;

      if (k == 0) begin : g_first
         assign rem_prev = rad;
         assign acc_prev = '0;
      end else begin : g_rest
         assign rem_prev = rem_ff[k-1];
         assign acc_prev = acc_ff[k-1];
      end

      assign trial = acc_prev + BIT_VAL;

      always_ff @(posedge clock) begin
         if (en[k]) begin
            if ({1'b0, rem_prev} >= trial) begin
               rem_ff[k] <= rem_prev - trial[RAD_W-1:0];
               acc_ff[k] <= (acc_prev >> 1) + BIT_VAL;
            end else begin
               rem_ff[k] <= rem_prev;
               acc_ff[k] <= acc_prev >> 1;
            end
         end
      end
   end

   assign root = acc_ff[SQRT_STG-1][LEN_W-1:0];

endmodule
`default_nettype wire

@@ hdl/vn_div_lane.sv @@
// One component lane: pipelined restoring divide of |c|*2^23 by the length.
`default_nettype none
module vn_div_lane import vn_pkg::*; (
   input  wire logic               clock,
   input  wire logic [DIV_STG-1:0] en,
   input  wire logic [COMP_W-1:0]  comp,
   input  wire logic [LEN_W-1:0]   len,
   output div_res_type             res
);

   logic [REM_W-1:0] rem_ff [DIV_STG];
   logic [LEN_W-1:0] len_ff [DIV_STG];
   logic [QUO_W-1:0] quo_ff [DIV_STG];
   logic             neg_ff [DIV_STG];
   logic             sat_ff [DIV_STG];
   logic [COMP_W-1:0] mag;

   assign mag = comp[COMP_W-1] ? COMP_W'(-comp) : comp;

   // quotient reaches 2^15 exactly when |c|*2^8 >= len
   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg_ff[0] <= comp[COMP_W-1];
         sat_ff[0] <= {1'b0, mag, 8'b0} >= REM_W'(len);
         rem_ff[0] <= {1'b0, mag, 8'b0};
         len_ff[0] <= len;
         quo_ff[0] <= '0;
      end
   end

   for (genvar j = 1; j < DIV_STG; j++) begin : g_stg
      logic [REM_W:0] shifted;
      logic           ge;

      assign shifted = {rem_ff[j-1], 1'b0};
      assign ge      = shifted >= {1'b0, len_ff[j-1]};

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= ge ? REM_W'(shifted - {1'b0, len_ff[j-1]}) : shifted[REM_W-1:0];
            quo_ff[j] <= {quo_ff[j-1][QUO_W-2:0], ge};
            len_ff[j] <= len_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            sat_ff[j] <= sat_ff[j-1];
         end
      end
   end

   assign res.neg = neg_ff[DIV_STG-1];
   assign res.sat = sat_ff[DIV_STG-1];
   assign res.quo = quo_ff[DIV_STG-1];

endmodule
`default_nettype wire

@@ hdl/vector_normalize.sv @@
// Vector normalize: four component lanes, square-sum merge, root and divide pipes.
//
// Input items arrive on req_valid/req_ready with a req_type payload; results
// leave on rsp_valid/rsp_ready as rsp_type. One result per item, in order.
// From acceptance to rsp_valid an item passes one input register, one
// squaring stage per lane, one merge stage that sums the squares and compares
// against min_squared_length, 25 root stages (one result bit each), 16 divide
// stages per lane (saturation check plus 15 quotient bits) and the output
// register. One item per cycle while rsp_ready is high; every stage holds an item.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled receiver only holds the full stages nearest the output; bubbles
// further up are squeezed out and req_ready stays high while any stage is free.
// Reset clears all stage valid bits and sets min_squared_length to zero.
// The threshold register sits at CSR byte address 0 (64-bit data) and must be
// written only while no item is in flight.
`default_nettype none
module vector_normalize import vn_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   logic [THR_W-1:0] thr_ff;
   logic [NUM_STG-1:0] valid_ff, valid_in, en;

   logic [LANES-1:0][COMP_W-1:0] comps_ff [ST_DIV0];
   logic [LANES-1:0][SQ_W-1:0]   sq_ff;
   logic [SUM_W-1:0]             sum_in, sum_ff;
   logic                         deg_ff [ST_SUM:ST_OUT-1];
   logic [LEN_W-1:0]             len_ff [ST_DIV0:ST_OUT-1];
   logic [LEN_W-1:0]             root;
   div_res_type                  res [LANES];
   rsp_type                      out_in, out_ff;
   logic                         use_z, use_w;

   // ---------------- config port ----------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_MIN_SQ_LEN) ? CSR_DW'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_MIN_SQ_LEN) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   // ---------------- stage flow control ----------------
   assign en[NUM_STG-1] = ~valid_ff[NUM_STG-1] | rsp_ready;
   for (genvar i = 0; i < NUM_STG - 1; i++) begin : g_en
      assign en[i] = ~valid_ff[i] | en[i+1];
   end

   always_comb begin
      for (int i = 0; i < NUM_STG; i++) begin
         if (!en[i]) valid_in[i] = valid_ff[i];
         else if (i == 0) valid_in[i] = req_valid;
         else valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[ST_IN];
   assign rsp_valid = valid_ff[ST_OUT];
   assign rsp_data  = out_ff;

   // ---------------- input, squares, merge ----------------
   assign use_z = req_data.component_count >= 3'd3;
   assign use_w = req_data.component_count >= 3'd4;

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         comps_ff[ST_IN] <= {use_w ? req_data.comp_w : 16'sd0,
                             use_z ? req_data.comp_z : 16'sd0,
                             req_data.comp_y, req_data.comp_x};
      end
      for (int i = 1; i < ST_DIV0; i++) begin
         if (en[i]) comps_ff[i] <= comps_ff[i-1];
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_sq
      logic signed [2*COMP_W-1:0] prod;
      assign prod = $signed(comps_ff[ST_IN][l]) * $signed(comps_ff[ST_IN][l]);
      always_ff @(posedge clock) begin
         if (en[ST_SQ]) sq_ff[l] <= prod[SQ_W-1:0];
      end
   end

   assign sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         sum_ff         <= sum_in;
         deg_ff[ST_SUM] <= sum_in <= thr_ff;
      end
      for (int i = ST_SUM + 1; i < ST_OUT; i++) begin
         if (en[i]) deg_ff[i] <= deg_ff[i-1];
      end
      if (en[ST_DIV0]) len_ff[ST_DIV0] <= root;
      for (int i = ST_DIV0 + 1; i < ST_OUT; i++) begin
         if (en[i]) len_ff[i] <= len_ff[i-1];
      end
   end

   // ---------------- root and divide lanes ----------------
   vn_sqrt u_sqrt (
      .clock (clock),
      .en    (en[ST_DIV0-1:ST_ROOT0]),
      .rad   ({sum_ff, 16'b0}),
      .root  (root)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_div
      vn_div_lane u_lane (
         .clock (clock),
         .en    (en[ST_OUT-1:ST_DIV0]),
         .comp  (comps_ff[ST_DIV0-1][l]),
         .len   (root),
         .res   (res[l])
      );
   end

   // ---------------- output register ----------------
   function automatic logic [COMP_W-1:0] unit_of(div_res_type r);
      logic [COMP_W-1:0] m;
      m = {1'b0, r.sat ? UNIT_MAX : r.quo};
      return r.neg ? COMP_W'(-m) : m;
   endfunction

   always_comb begin
      if (deg_ff[ST_OUT-1]) begin
         out_in            = '0;
         out_in.degenerate = 1'b1;
      end else begin
         out_in.unit_x     = unit_of(res[0]);
         out_in.unit_y     = unit_of(res[1]);
         out_in.unit_z     = unit_of(res[2]);
         out_in.unit_w     = unit_of(res[3]);
         out_in.length     = len_ff[ST_OUT-1];
         out_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) out_ff <= out_in;
   end

endmodule
`default_nettype wire

@@ hdl/vn_check.sv @@
// Port-level checks for vector_normalize, bound to the top level.
`default_nettype none
module vn_check import vn_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.length == 0 && rsp_data.unit_x == 0
      && rsp_data.unit_y == 0 && rsp_data.unit_z == 0 && rsp_data.unit_w == 0)
      else $error("degenerate item with nonzero fields");

   a_len_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |-> rsp_data.length >= 25'd256)
      else $error("normalized item with length below one");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.unit_x != 16'sh8000 && rsp_data.unit_y != 16'sh8000
      && rsp_data.unit_z != 16'sh8000 && rsp_data.unit_w != 16'sh8000)
      else $error("unit component not saturated");

endmodule

bind vector_normalize vn_check u_vn_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for vector_normalize: random and directed vectors, APB threshold.
`default_nettype none
module tb_top;
   import vn_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   localparam int LIMIT_CYCLES = 400000;

   vector_normalize DUT (.*);

   always #10 clock = ~clock;

   req_type     vec_queue[$];
   rsp_type     unit_queue[$];
   logic [32:0] threshold;
   int          fail_count = 0;
   int          rsp_count = 0;
   int          degen_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   function automatic logic [24:0] isqrt_floor(logic [63:0] n);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return root[24:0];
   endfunction

   function automatic logic signed [15:0] unit_comp(logic signed [15:0] c, logic [24:0] len);
      logic [63:0] mag, q;
      mag = c < 0 ? 64'(-32'(c)) : 64'(c);
      q = (mag << 23) / 64'(len);
      if (q > 32767) q = 32767;
      return c < 0 ? -16'(q) : 16'(q);
   endfunction

   function automatic rsp_type normalize(req_type v);
      rsp_type r;
      logic signed [15:0] c[4];
      logic [63:0] sum;
      logic [24:0] len;
      c[0] = v.comp_x;
      c[1] = v.comp_y;
      c[2] = (v.component_count >= 3) ? v.comp_z : 16'sd0;
      c[3] = (v.component_count >= 4) ? v.comp_w : 16'sd0;
      sum = 0;
      for (int i = 0; i < 4; i++) sum += 64'(32'(c[i]) * 32'(c[i]));
      r = '0;
      if (sum > 64'(threshold)) begin
         len = isqrt_floor(sum << 16);
         r.unit_x = unit_comp(c[0], len);
         r.unit_y = unit_comp(c[1], len);
         r.unit_z = unit_comp(c[2], len);
         r.unit_w = unit_comp(c[3], len);
         r.length = len;
      end else begin
         r.degenerate = 1;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            unit_queue.push_back(normalize(req_data));
            void'(vec_queue.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            // vec_queue[0] is next once the accepted one is popped
            if (vec_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1;
               req_data  <= vec_queue[0];
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_type e;
            rsp_count++;
            if (unit_queue.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               e = unit_queue.pop_front();
               if (e.degenerate) degen_count++;
               if (rsp_data.unit_x !== e.unit_x) report_mismatch("unit_x", rsp_data.unit_x, e.unit_x);
               if (rsp_data.unit_y !== e.unit_y) report_mismatch("unit_y", rsp_data.unit_y, e.unit_y);
               if (rsp_data.unit_z !== e.unit_z) report_mismatch("unit_z", rsp_data.unit_z, e.unit_z);
               if (rsp_data.unit_w !== e.unit_w) report_mismatch("unit_w", rsp_data.unit_w, e.unit_w);
               if (rsp_data.length !== e.length) report_mismatch("length", rsp_data.length, e.length);
               if (rsp_data.degenerate !== e.degenerate)
                  report_mismatch("degenerate", rsp_data.degenerate, e.degenerate);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_threshold(logic [32:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= ADDR_MIN_SQ_LEN; csr_pwdata <= 64'(value);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      threshold = value;
   endtask

   task automatic add_vec(logic [2:0] n, logic [15:0] x, logic [15:0] y,
                          logic [15:0] z, logic [15:0] w);
      req_type v;
      v.component_count = n;
      v.comp_x = x; v.comp_y = y; v.comp_z = z; v.comp_w = w;
      vec_queue.push_back(v);
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(7)) - 16'd3;
         3: return 16'($urandom_range(511)) - 16'd256;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic drain();
      wait (vec_queue.size() == 0 && !req_valid && unit_queue.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      logic [32:0] thr_set[5];
      int          idle_set[4][2];
      thr_set = '{33'd0, 33'd1000, 33'd50_000_000, 33'h0_ffff_ffff, 33'h1_0000_0000};
      idle_set = '{'{0, 0}, '{55, 0}, '{0, 55}, '{26, 26}};
      threshold = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      write_threshold(0);

      // directed: extremes, counts 0..7, zero vector, full-scale negative
      add_vec(2, 16'h8000, 0, 0, 0);
      add_vec(2, 16'h7fff, 0, 0, 0);
      add_vec(4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_vec(4, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      add_vec(0, 3, 4, 16'h7fff, 16'h8000);
      add_vec(1, 16'hfffd, 4, 5, 6);
      add_vec(3, 1, 2, 16'h8000, 16'h7fff);
      add_vec(5, 1, 1, 1, 1);
      add_vec(6, 0, 0, 0, 16'h8000);
      add_vec(7, 0, 0, 0, 16'h8000);
      add_vec(4, 0, 0, 0, 0);
      add_vec(2, 1, 0, 0, 0);
      add_vec(4, 0, 0, 16'h8000, 0);
      add_vec(3, 16'hffff, 16'hffff, 16'hffff, 16'h5555);
      add_vec(4, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
      drain();

      // random phases across thresholds and idle mixes
      for (int p = 0; p < 20; p++) begin
         send_idle_pct  = idle_set[p % 4][0];
         recv_stall_pct = idle_set[p % 4][1];
         if (p % 4 == 0) write_threshold(thr_set[(p / 4) % 5]);
         else if (p == 10) write_threshold(33'($urandom_range(100000)));
         for (int i = 0; i < 95; i++)
            add_vec(3'($urandom_range(7)), rand_comp(), rand_comp(), rand_comp(), rand_comp());
         drain();
      end

      $display("covered %0d results (%0d degenerate) over 5 thresholds and 4 idle mixes",
               rsp_count, degen_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
